[hw/rtl/adc_regular_sequence_scanner_defines.svh]
// Assertion macros shared by the ADC sequence scanner RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef ADC_REGULAR_SEQUENCE_SCANNER_DEFINES_SVH
`define ADC_REGULAR_SEQUENCE_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ARSS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/arss_pkg.sv]
// Package for the ADC regular sequence scanner: item layout, register map,
// decoded command type and shared constants. No dependencies.
package arss_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    localparam logic [8:0]  MAX_OFFSET   = 9'h04C;
    localparam logic [4:0]  SLOT_MASK    = 5'h1f;
    localparam int          START_BIT    = 30;
    localparam int          CONT_BIT     = 1;
    localparam int          LEN_SHIFT    = 20;
    localparam logic [31:0] HTR_RESET    = 32'h0000_0fff;
    localparam int          VBAT_CHANNEL = 8;
    localparam logic [15:0] VBAT_LEVEL   = 16'(24 * 4096 / 39);

    localparam logic [4:0] REG_SR    = 5'd0;
    localparam logic [4:0] REG_CR1   = 5'd1;
    localparam logic [4:0] REG_CR2   = 5'd2;
    localparam logic [4:0] REG_SMPR1 = 5'd3;
    localparam logic [4:0] REG_SMPR2 = 5'd4;
    localparam logic [4:0] REG_JOFR1 = 5'd5;
    localparam logic [4:0] REG_JOFR2 = 5'd6;
    localparam logic [4:0] REG_JOFR3 = 5'd7;
    localparam logic [4:0] REG_JOFR4 = 5'd8;
    localparam logic [4:0] REG_HTR   = 5'd9;
    localparam logic [4:0] REG_LTR   = 5'd10;
    localparam logic [4:0] REG_SQR1  = 5'd11;
    localparam logic [4:0] REG_SQR2  = 5'd12;
    localparam logic [4:0] REG_SQR3  = 5'd13;
    localparam logic [4:0] REG_JSQR  = 5'd14;
    localparam logic [4:0] REG_JDR1  = 5'd15;
    localparam logic [4:0] REG_JDR2  = 5'd16;
    localparam logic [4:0] REG_JDR3  = 5'd17;
    localparam logic [4:0] REG_JDR4  = 5'd18;
    localparam logic [4:0] REG_DR    = 5'd19;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_TICK   = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [4:0]  reg_idx;
        logic        acc_err;
        logic [31:0] wdata;
        logic [3:0]  chan;
        logic [15:0] sample;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[hw/rtl/arss_front.sv]
// Front end of the ADC sequence scanner: accepts input items, decodes the
// register offset and access errors, pushes commands. Depends on arss_pkg.
module arss_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [arss_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [arss_pkg::S_TUSER_W-1:0]  s_tuser,
    input  arss_pkg::queue_status_t         q_status,
    output logic                            push,
    output arss_pkg::cmd_t                  cmd
);

    logic [8:0] offset;
    logic       aligned;
    logic [4:0] idx;
    logic       wr_forbidden;

    assign offset  = s_tdata[8:0];
    assign aligned = (offset[1:0] == 2'b00) && (offset <= arss_pkg::MAX_OFFSET);
    assign idx     = offset[6:2];

    // status, injected data and data register are read-only
    assign wr_forbidden = (idx == arss_pkg::REG_SR) || (idx >= arss_pkg::REG_JDR1);

    always_comb begin
        cmd.kind    = arss_pkg::req_kind_t'(s_tuser);
        cmd.reg_idx = idx;
        cmd.wdata   = s_tdata[40:9];
        cmd.chan    = s_tdata[44:41];
        cmd.sample  = s_tdata[60:45];
        unique case (cmd.kind)
            arss_pkg::REQ_WRITE: cmd.acc_err = !aligned || wr_forbidden;
            arss_pkg::REQ_READ:  cmd.acc_err = !aligned;
            default:             cmd.acc_err = 1'b0;
        endcase
    end

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

endmodule

[hw/rtl/arss_queue.sv]
// Command queue between front and back end of the ADC sequence scanner.
// Depends on arss_pkg and the assertion macro header.
`include "adc_regular_sequence_scanner_defines.svh"

module arss_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  arss_pkg::cmd_t          cmd_in,
    input  logic                    pop,
    output arss_pkg::cmd_t          cmd_out,
    output arss_pkg::queue_status_t q_status
);

    localparam int DEPTH = arss_pkg::QUEUE_DEPTH;
    localparam int PTR_W = arss_pkg::QUEUE_PTR_W;
    localparam int CNT_W = arss_pkg::QUEUE_CNT_W;

    arss_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_out        = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);

    `ARSS_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `ARSS_ASSERT_IMPLY(a_no_push_full, q_status.full, !push, "push into full queue")
    `ARSS_ASSERT_NEXT(a_pop_drains, pop && !push, count_reg == $past(count_reg) - 1'b1, "pop lost")

endmodule

[hw/rtl/arss_back.sv]
// Back end of the ADC sequence scanner: register file, channel samples,
// sequence scan and output register. Depends on arss_pkg and the macro header.
`include "adc_regular_sequence_scanner_defines.svh"

module arss_back #(
    parameter int NUM_CHANNELS = arss_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  arss_pkg::cmd_t                  cmd,
    input  arss_pkg::queue_status_t         q_status,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [arss_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [arss_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);

    localparam int CH_W = $clog2(NUM_CHANNELS);
    localparam int LEN_SHIFT_HI = arss_pkg::LEN_SHIFT + 3;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  slot_reg, slot_next;
    logic [31:0] ctrl_one_reg, ctrl_one_next;
    logic [31:0] ctrl_two_reg, ctrl_two_next;
    logic [31:0] smpr_one_reg, smpr_one_next;
    logic [31:0] smpr_two_reg, smpr_two_next;
    logic [31:0] jofr_reg [4];
    logic [31:0] jofr_next [4];
    logic [31:0] htr_reg, htr_next;
    logic [31:0] ltr_reg, ltr_next;
    logic [31:0] sqr_reg [3];
    logic [31:0] sqr_next [3];
    logic [31:0] jsqr_reg, jsqr_next;
    logic [31:0] data_reg, data_next;
    logic [15:0] samples_reg [NUM_CHANNELS];
    logic [15:0] samples_next [NUM_CHANNELS];

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [arss_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [arss_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                           m_tlast_reg, m_tlast_next;

    logic        out_free;
    logic [3:0]  seq_len;
    logic [79:0] slot_vec;
    logic [4:0]  slot_id;
    logic [15:0] slot_sample;
    logic [31:0] rd_value;
    logic [1:0]  jofr_sel;
    logic [1:0]  sqr_sel;

    assign out_free = !m_tvalid_reg || m_tready;
    assign seq_len  = sqr_reg[0][LEN_SHIFT_HI:arss_pkg::LEN_SHIFT];

    // slots in scan order: six from SQR3, six from SQR2, four from SQR1
    assign slot_vec    = {sqr_reg[0][19:0], sqr_reg[1][29:0], sqr_reg[2][29:0]};
    assign slot_id     = slot_vec[({3'b000, slot_reg} * 7'd5) +: 5] & arss_pkg::SLOT_MASK;
    assign slot_sample = (32'(slot_id) < NUM_CHANNELS) ? samples_reg[slot_id[CH_W-1:0]]
                                                        : 16'h0000;

    assign jofr_sel = 2'(cmd.reg_idx - arss_pkg::REG_JOFR1);
    assign sqr_sel  = 2'(cmd.reg_idx - arss_pkg::REG_SQR1);

    always_comb begin
        unique case (cmd.reg_idx)
            arss_pkg::REG_CR1:   rd_value = ctrl_one_reg;
            arss_pkg::REG_CR2:   rd_value = ctrl_two_reg;
            arss_pkg::REG_SMPR1: rd_value = smpr_one_reg;
            arss_pkg::REG_SMPR2: rd_value = smpr_two_reg;
            arss_pkg::REG_JOFR1, arss_pkg::REG_JOFR2,
            arss_pkg::REG_JOFR3, arss_pkg::REG_JOFR4: rd_value = jofr_reg[jofr_sel];
            arss_pkg::REG_HTR:   rd_value = htr_reg;
            arss_pkg::REG_LTR:   rd_value = ltr_reg;
            arss_pkg::REG_SQR1, arss_pkg::REG_SQR2,
            arss_pkg::REG_SQR3:  rd_value = sqr_reg[sqr_sel];
            arss_pkg::REG_JSQR:  rd_value = jsqr_reg;
            arss_pkg::REG_DR:    rd_value = data_reg;
            // status and injected data never change from zero
            default:             rd_value = 32'h0000_0000;
        endcase
        if (cmd.acc_err) begin
            rd_value = 32'h0000_0000;
        end
    end

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        ctrl_one_next = ctrl_one_reg;
        ctrl_two_next = ctrl_two_reg;
        smpr_one_next = smpr_one_reg;
        smpr_two_next = smpr_two_reg;
        jofr_next     = jofr_reg;
        htr_next      = htr_reg;
        ltr_next      = ltr_reg;
        sqr_next      = sqr_reg;
        jsqr_next     = jsqr_reg;
        data_next     = data_reg;
        samples_next  = samples_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty && out_free) begin
                    pop = 1'b1;
                    unique case (cmd.kind)
                        arss_pkg::REQ_WRITE: begin
                            if (!cmd.acc_err) begin
                                unique case (cmd.reg_idx)
                                    arss_pkg::REG_CR1:   ctrl_one_next = cmd.wdata;
                                    arss_pkg::REG_CR2:   ctrl_two_next = cmd.wdata;
                                    arss_pkg::REG_SMPR1: smpr_one_next = cmd.wdata;
                                    arss_pkg::REG_SMPR2: smpr_two_next = cmd.wdata;
                                    arss_pkg::REG_JOFR1, arss_pkg::REG_JOFR2,
                                    arss_pkg::REG_JOFR3, arss_pkg::REG_JOFR4:
                                        jofr_next[jofr_sel] = cmd.wdata;
                                    arss_pkg::REG_HTR:   htr_next = cmd.wdata;
                                    arss_pkg::REG_LTR:   ltr_next = cmd.wdata;
                                    arss_pkg::REG_SQR1, arss_pkg::REG_SQR2,
                                    arss_pkg::REG_SQR3:  sqr_next[sqr_sel] = cmd.wdata;
                                    arss_pkg::REG_JSQR:  jsqr_next = cmd.wdata;
                                    default: ;
                                endcase
                            end
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = {2'b00, 16'h0000, 5'h00, cmd.acc_err, 32'h0};
                            m_tuser_next  = 1'b0;
                            m_tlast_next  = 1'b1;
                        end
                        arss_pkg::REQ_READ: begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = {2'b00, 16'h0000, 5'h00, cmd.acc_err, rd_value};
                            m_tuser_next  = 1'b0;
                            m_tlast_next  = 1'b1;
                        end
                        arss_pkg::REQ_SAMPLE: begin
                            if (32'(cmd.chan) < NUM_CHANNELS) begin
                                samples_next[CH_W'(cmd.chan)] = cmd.sample;
                            end
                        end
                        arss_pkg::REQ_TICK: begin
                            if (ctrl_two_reg[arss_pkg::START_BIT]) begin
                                state_next = ST_SCAN;
                                slot_next  = 4'h0;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    data_next     = {{16{slot_sample[15]}}, slot_sample};
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, slot_sample, slot_id, 1'b0, 32'h0};
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = (slot_reg == seq_len);
                    slot_next     = slot_reg + 1'b1;
                    if (slot_reg == seq_len) begin
                        state_next = ST_IDLE;
                        if (!ctrl_two_reg[arss_pkg::CONT_BIT]) begin
                            ctrl_two_next[arss_pkg::START_BIT] = 1'b0;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            ctrl_one_reg <= '0;
            ctrl_two_reg <= '0;
            smpr_one_reg <= '0;
            smpr_two_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                jofr_reg[i] <= '0;
            end
            htr_reg <= arss_pkg::HTR_RESET;
            ltr_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                sqr_reg[i] <= '0;
            end
            jsqr_reg <= '0;
            data_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                samples_reg[i] <= (i == arss_pkg::VBAT_CHANNEL) ? arss_pkg::VBAT_LEVEL
                                                                : 16'h0000;
            end
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            ctrl_one_reg <= ctrl_one_next;
            ctrl_two_reg <= ctrl_two_next;
            smpr_one_reg <= smpr_one_next;
            smpr_two_reg <= smpr_two_next;
            jofr_reg     <= jofr_next;
            htr_reg      <= htr_next;
            ltr_reg      <= ltr_next;
            sqr_reg      <= sqr_next;
            jsqr_reg     <= jsqr_next;
            data_reg     <= data_next;
            samples_reg  <= samples_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ARSS_ASSERT_IMPLY(a_no_pop_in_scan, state_reg == ST_SCAN, !pop, "queue popped mid-scan")
    `ARSS_ASSERT_IMPLY(a_conv_clean, m_tvalid_reg && m_tuser_reg[0], m_tdata_reg[32:0] == '0, "conversion carries bus fields")
    `ARSS_ASSERT_NEXT(a_scan_ends, state_reg == ST_SCAN && out_free && slot_reg == seq_len, state_reg == ST_IDLE && m_tlast_reg, "scan overran")
    `ARSS_ASSERT_NEXT(a_tick_starts, pop && cmd.kind == arss_pkg::REQ_TICK && ctrl_two_reg[arss_pkg::START_BIT], state_reg == ST_SCAN && slot_reg == 4'h0, "tick did not start scan")

endmodule

[hw/rtl/adc_regular_sequence_scanner.sv]
// Channel    | Dir | tdata (low bit up)                                  | tuser    | tlast
// s_ request | in  | reg_offset, write_data, channel, sample_value, pad  | req_type | -
// m_ result  | out | read_data, access_error, conv_channel, conv_data,pad| conv_valid | last
// Bus writes and reads each give a result that is registered into the output register
// when the back end pops the item from the queue; sample updates give none. A tick with the
// start bit set starts a scan that takes the sequence one slot at a time, up to 16 slots,
// and emits one result per slot whenever the output register is free to take it.
// Reset (aresetn low, synchronous) empties the queue and the output register and
// loads the register and sample reset values. A stalled result holds in the output
// register while the queue keeps taking items until it fills.
module adc_regular_sequence_scanner #(
    parameter int NUM_CHANNELS = arss_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [arss_pkg::S_TDATA_W-1:0]  s_tdata,   // [8:0] reg_offset, [40:9] write_data,
                                                       // [44:41] channel, [60:45] sample_value
    input  logic [arss_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [arss_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] read_data, [32] access_error,
                                                       // [37:33] conv_channel, [53:38] conv_data
    output logic [arss_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] conv_valid
    output logic                            m_tlast
);

    arss_pkg::queue_status_t q_status;
    arss_pkg::cmd_t          push_cmd;
    arss_pkg::cmd_t          head_cmd;
    logic                    push;
    logic                    pop;

    arss_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    arss_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .cmd_in   (push_cmd),
        .pop      (pop),
        .cmd_out  (head_cmd),
        .q_status (q_status)
    );

    arss_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
